// ===== sv/scct_pkg.sv =====
package scct_pkg;

    localparam logic [7:0] TYPE_PACKED = 8'h05;
    localparam logic [7:0] TYPE_BYTES  = 8'h85;
    localparam logic [7:0] CODE_REL    = 8'h0c;
    localparam logic [7:0] CODE_ANM    = 8'h09;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_IDLE    = 2'd1;
    localparam logic [1:0] ST_ACTIVE  = 2'd2;

    localparam logic [1:0] STS_IGNORED = 2'd0;
    localparam logic [1:0] STS_APPLIED = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;
    localparam logic [1:0] STS_RANGE   = 2'd3;

    localparam int SLOTS = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAIR_SCAN,
        S_PCM_SCAN,
        S_CLEAR,
        S_SLOT_RD,
        S_SLOT_WAIT,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic pair_start;
        logic pair_step;
        logic pcm_start;
        logic pcm_step;
        logic pcm_alloc;
        logic clr_step;
        logic slot_rd;
        logic update;
        logic set_full;
        logic set_range;
        logic set_ignored;
    } t_cmd;

    typedef struct packed {
        logic valid_type;
        logic pair_done;
        logic pair_found;
        logic pcm_done;
        logic pcm_found;
        logic pcm_new;
        logic clr_done;
        logic ts_range;
    } t_sts;

endpackage

// ===== sv/scct_ram.sv =====
module scct_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/scct_ctrl.sv =====
module scct_ctrl
    import scct_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output t_state o_state
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PAIR_SCAN;
            end
            S_PAIR_SCAN: begin
                if (!i_sts.valid_type) n_state = S_OUT;
                else if (i_sts.pair_done) begin
                    n_state = i_sts.pair_found ? S_PCM_SCAN : S_OUT;
                end
            end
            S_PCM_SCAN: begin
                if (i_sts.pcm_done) begin
                    if (!i_sts.pcm_found) n_state = S_OUT;
                    else if (i_sts.pcm_new) n_state = S_CLEAR;
                    else if (i_sts.ts_range) n_state = S_OUT;
                    else n_state = S_SLOT_RD;
                end
            end
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = i_sts.ts_range ? S_OUT : S_SLOT_RD;
            end
            S_SLOT_RD:   n_state = S_SLOT_WAIT;
            S_SLOT_WAIT: n_state = S_UPDATE;
            S_UPDATE:    n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_PAIR_SCAN: begin
                o_cmd.set_ignored = !i_sts.valid_type;
                o_cmd.pair_step = i_sts.valid_type && !i_sts.pair_done;
                o_cmd.pcm_start = i_sts.valid_type && i_sts.pair_done && i_sts.pair_found;
                o_cmd.set_full = i_sts.valid_type && i_sts.pair_done && !i_sts.pair_found;
            end
            S_PCM_SCAN: begin
                o_cmd.pcm_step = !i_sts.pcm_done;
                o_cmd.pcm_alloc = i_sts.pcm_done && i_sts.pcm_new;
                o_cmd.set_full = i_sts.pcm_done && !i_sts.pcm_found;
                o_cmd.set_range = i_sts.pcm_done && i_sts.pcm_found && !i_sts.pcm_new
                                  && i_sts.ts_range;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.set_range = i_sts.clr_done && i_sts.ts_range;
            end
            S_SLOT_RD: o_cmd.slot_rd = 1'b1;
            S_UPDATE:  o_cmd.update = 1'b1;
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_state     = r_state;

endmodule

// ===== sv/scct_dp.sv =====
module scct_dp
    import scct_pkg::*;
#(
    parameter int MAX_PAIRS     = 16,
    parameter int PCMS_PER_PAIR = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_record_type,
    input  logic [63:0] i_body_low,
    input  logic [15:0] i_body_high,
    output t_sts        o_sts,
    output logic [1:0]  o_status,
    output logic [1:0]  o_circuit_state,
    output logic [5:0]  o_pcm_active,
    output logic [8:0]  o_pair_active,
    output logic [12:0] o_total_active
);

    localparam int NUM_PCMS = MAX_PAIRS * PCMS_PER_PAIR;
    localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = (PCMS_PER_PAIR > 1) ? $clog2(PCMS_PER_PAIR) : 1;
    localparam int EW = (NUM_PCMS > 1) ? $clog2(NUM_PCMS) : 1;
    localparam int SW = $clog2(NUM_PCMS * SLOTS);
    localparam int PCW = $clog2(MAX_PAIRS + 1);
    localparam int ICW = $clog2(PCMS_PER_PAIR + 1);

    logic [47:0] r_pair_keys [MAX_PAIRS];
    logic [MAX_PAIRS-1:0] r_pair_valid;
    logic [8:0]  r_pair_cnt [MAX_PAIRS];
    logic [NUM_PCMS-1:0] r_pcm_valid;
    logic [12:0] r_total;

    logic [47:0] r_fwd, r_rev;
    logic [7:0]  r_pcm, r_ts, r_code;
    logic        r_vtype;
    logic [PCW-1:0] r_pidx;
    logic [PW-1:0]  r_pair;
    logic        r_pfound, r_pfree_seen;
    logic [PW-1:0]  r_pfree;
    logic [ICW-1:0] r_cidx;
    logic        r_cph;
    logic [EW-1:0]  r_pe;
    logic        r_cfound, r_cfree_seen;
    logic [CW-1:0]  r_cfree;
    logic [4:0]  r_clr;
    logic        r_clr_done;
    logic [1:0]  r_status, r_cs;
    logic [5:0]  r_pcm_out;
    logic [8:0]  r_pair_out;

    logic [1:0]  w_slot_rd;
    logic        w_we;
    logic [SW-1:0] w_waddr;
    logic [1:0]  w_wdata;
    logic [1:0]  n_cs;
    logic        w_inc, w_dec;
    logic [PW-1:0] w_pi;
    logic [EW-1:0] w_ci;
    logic [EW-1:0] w_pe_new;
    logic [31:0] w_l;
    logic [15:0] w_c;
    logic [13:0] w_pcm_rd;
    logic [5:0]  w_pcm_next;
    logic        w_pwe;
    logic [EW-1:0] w_pwaddr;
    logic [13:0] w_pwdata;
    logic [EW-1:0] w_praddr;

    assign w_l  = i_body_low[31:0];
    assign w_c  = i_body_low[47:32];
    assign w_pi = r_pidx[PW-1:0];
    assign w_ci = EW'(r_pair) * EW'(PCMS_PER_PAIR) + EW'(r_cidx[CW-1:0]);
    assign w_pe_new = EW'(r_pair) * EW'(PCMS_PER_PAIR) + EW'(r_cfree);
    assign w_pcm_next = w_pcm_rd[5:0] + {5'd0, w_inc} - {5'd0, w_dec};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vtype <= (i_record_type == TYPE_PACKED) || (i_record_type == TYPE_BYTES);
            if (i_record_type == TYPE_PACKED) begin
                r_fwd <= {5'd0, w_l[27:25], w_l[24:17], 5'd0, w_l[16:14],
                          5'd0, w_l[13:11], w_l[10:3], 5'd0, w_l[2:0]};
                r_rev <= {5'd0, w_l[13:11], w_l[10:3], 5'd0, w_l[2:0],
                          5'd0, w_l[27:25], w_l[24:17], 5'd0, w_l[16:14]};
                r_pcm  <= {1'b0, w_c[11:5]};
                r_ts   <= {3'd0, w_c[4:0]};
                r_code <= i_body_low[55:48];
            end else begin
                r_fwd <= {i_body_low[23:16], i_body_low[15:8], i_body_low[7:0],
                          i_body_low[47:40], i_body_low[39:32], i_body_low[31:24]};
                r_rev <= {i_body_low[47:40], i_body_low[39:32], i_body_low[31:24],
                          i_body_low[23:16], i_body_low[15:8], i_body_low[7:0]};
                r_ts   <= i_body_low[63:56];
                r_pcm  <= i_body_high[7:0];
                r_code <= i_body_high[15:8];
            end
            r_pidx <= '0;
            r_pfound <= 1'b0;
            r_pfree_seen <= 1'b0;
            r_status <= STS_APPLIED;
            r_cs <= ST_UNKNOWN;
            r_pcm_out <= '0;
            r_pair_out <= '0;
        end
        if (i_cmd.pair_step) begin
            if (r_pair_valid[w_pi] &&
                (r_pair_keys[w_pi] == r_fwd || r_pair_keys[w_pi] == r_rev)) begin
                r_pfound <= 1'b1;
                r_pair <= w_pi;
            end else if (!r_pair_valid[w_pi] && !r_pfree_seen) begin
                r_pfree_seen <= 1'b1;
                r_pfree <= w_pi;
            end
            r_pidx <= r_pidx + 1'b1;
        end
        if (i_cmd.pcm_start) begin
            r_cidx <= '0;
            r_cph <= 1'b0;
            r_cfound <= 1'b0;
            r_cfree_seen <= 1'b0;
            r_pair_out <= r_pfound ? r_pair_cnt[r_pair] : 9'd0;
            if (!r_pfound) begin
                r_pair <= r_pfree;
                r_pair_keys[r_pfree] <= r_fwd;
            end
        end
        if (i_cmd.pcm_step) begin
            r_cph <= !r_cph;
            if (r_cph) begin
                if (r_pcm_valid[w_ci] && w_pcm_rd[13:6] == r_pcm) begin
                    r_cfound <= 1'b1;
                    r_pe <= w_ci;
                end else if (!r_pcm_valid[w_ci] && !r_cfree_seen) begin
                    r_cfree_seen <= 1'b1;
                    r_cfree <= r_cidx[CW-1:0];
                end
                r_cidx <= r_cidx + 1'b1;
            end
        end
        if (i_cmd.pcm_alloc) begin
            r_cfound <= 1'b1;
            r_pe <= w_pe_new;
            r_clr <= '0;
            r_clr_done <= 1'b0;
        end
        if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
            r_clr_done <= (r_clr == 5'd30);
        end
        if (i_cmd.set_ignored) begin
            r_status <= STS_IGNORED;
        end
        if (i_cmd.set_full) begin
            r_status <= STS_FULL;
        end
        if (i_cmd.set_range) begin
            r_status <= STS_RANGE;
            r_pcm_out <= w_pcm_rd[5:0];
        end
        if (i_cmd.update) begin
            r_cs <= n_cs;
            r_pcm_out <= w_pcm_next;
            r_pair_out <= r_pair_cnt[r_pair] + {8'd0, w_inc} - {8'd0, w_dec};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_valid <= '0;
            r_pcm_valid <= '0;
            r_total <= '0;
            for (int i = 0; i < MAX_PAIRS; i++) r_pair_cnt[i] <= '0;
        end else begin
            if (i_cmd.pcm_start && !r_pfound) begin
                r_pair_valid[r_pfree] <= 1'b1;
                r_pair_cnt[r_pfree] <= '0;
            end
            if (i_cmd.pcm_alloc) begin
                r_pcm_valid[w_pe_new] <= 1'b1;
            end
            if (i_cmd.update) begin
                r_pair_cnt[r_pair] <= r_pair_cnt[r_pair] + {8'd0, w_inc} - {8'd0, w_dec};
                r_total <= r_total + {12'd0, w_inc} - {12'd0, w_dec};
            end
        end
    end

    always_comb begin
        n_cs = w_slot_rd;
        w_inc = 1'b0;
        w_dec = 1'b0;
        if (w_slot_rd == ST_ACTIVE) begin
            if (r_code == CODE_REL) begin
                n_cs = ST_IDLE;
                w_dec = 1'b1;
            end
        end else if (r_code == CODE_ANM) begin
            n_cs = ST_ACTIVE;
            w_inc = 1'b1;
        end else if (r_code == CODE_REL && w_slot_rd == ST_UNKNOWN) begin
            n_cs = ST_IDLE;
        end
    end

    always_comb begin
        w_we = 1'b0;
        w_waddr = {r_pe, r_ts[4:0]};
        w_wdata = n_cs;
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
            w_waddr = {r_pe, r_clr};
            w_wdata = ST_UNKNOWN;
        end else if (i_cmd.update) begin
            w_we = 1'b1;
        end
    end

    always_comb begin
        w_pwe = i_cmd.pcm_alloc || i_cmd.update;
        w_pwaddr = r_pe;
        w_pwdata = {r_pcm, w_pcm_next};
        if (i_cmd.pcm_alloc) begin
            w_pwaddr = w_pe_new;
            w_pwdata = {r_pcm, 6'd0};
        end
    end

    assign w_praddr = r_cfound ? r_pe : w_ci;

    scct_ram #(.WIDTH(2), .DEPTH(NUM_PCMS * SLOTS)) u_slots (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr({r_pe, r_ts[4:0]}),
        .o_rdata(w_slot_rd)
    );

    scct_ram #(.WIDTH(14), .DEPTH(NUM_PCMS)) u_pcms (
        .i_clk  (i_clk),
        .i_we   (w_pwe),
        .i_waddr(w_pwaddr),
        .i_wdata(w_pwdata),
        .i_raddr(w_praddr),
        .o_rdata(w_pcm_rd)
    );

    always_comb begin
        o_sts = '0;
        o_sts.valid_type = r_vtype;
        o_sts.pair_done  = r_pfound || (r_pidx == PCW'(MAX_PAIRS));
        o_sts.pair_found = r_pfound || r_pfree_seen;
        o_sts.pcm_done   = r_cfound || (r_cidx == ICW'(PCMS_PER_PAIR));
        o_sts.pcm_found  = r_cfound || r_cfree_seen;
        o_sts.pcm_new    = !r_cfound && r_cfree_seen;
        o_sts.clr_done   = r_clr_done;
        o_sts.ts_range   = (r_ts >= 8'(SLOTS));
    end

    assign o_status        = r_status;
    assign o_circuit_state = r_cs;
    assign o_pcm_active    = r_pcm_out;
    assign o_pair_active   = r_pair_out;
    assign o_total_active  = r_total;

endmodule

// ===== sv/signalling_circuit_call_tracker.sv =====
// Sequence from accepting edge to valid result: an ignored type ends at the type check;
// otherwise a pair scan over up to MAX_PAIRS entries, a PCM scan reading each entry of the
// pair from PCM RAM, 32 slot clears on a new PCM, then a slot read-modify-write.
// Throughput: one transaction at a time; the next is accepted in the cycle after the result leaves.
// Reset: synchronous active-low; clears valid bits and counters. Slot RAM and PCM RAM
// need no clearing since a new PCM entry writes its own count and slots.
module signalling_circuit_call_tracker
    import scct_pkg::*;
#(
    parameter int MAX_PAIRS     = 16,
    parameter int PCMS_PER_PAIR = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // record_type, body_low, body_high
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // status, circuit_state, pcm_active, pair_active, total_active
);

    t_cmd   w_cmd;
    t_sts   w_sts;
    t_state w_state;
    logic [1:0]  w_status, w_cs;
    logic [5:0]  w_pcm;
    logic [8:0]  w_pair;
    logic [12:0] w_total;

    scct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    scct_dp #(.MAX_PAIRS(MAX_PAIRS), .PCMS_PER_PAIR(PCMS_PER_PAIR)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_record_type  (s_axis_tdata[7:0]),
        .i_body_low     (s_axis_tdata[71:8]),
        .i_body_high    (s_axis_tdata[87:72]),
        .o_sts          (w_sts),
        .o_status       (w_status),
        .o_circuit_state(w_cs),
        .o_pcm_active   (w_pcm),
        .o_pair_active  (w_pair),
        .o_total_active (w_total)
    );

    assign m_axis_tdata = {w_total, w_pair, w_pcm, w_cs, w_status};

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> w_state == S_IDLE) else $error("load outside idle");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("no return to idle");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import scct_pkg::*;

    localparam int NUM_PAIRS = 16;
    localparam int PCMS_PER = 8;
    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;  // record_type, body_low, body_high
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // status, circuit_state, pcm_active, pair_active, total_active

    typedef struct packed {
        logic [12:0] total_act;
        logic [8:0]  pair_act;
        logic [5:0]  pcm_act;
        logic [1:0]  cstate;
        logic [1:0]  status;
    } t_call_result;

    signalling_circuit_call_tracker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [47:0] trk_key [NUM_PAIRS];
    logic        trk_pair_vld [NUM_PAIRS];
    logic [8:0]  trk_pair_cnt [NUM_PAIRS];
    logic [7:0]  trk_pcm_id [NUM_PAIRS*PCMS_PER];
    logic        trk_pcm_vld [NUM_PAIRS*PCMS_PER];
    logic [5:0]  trk_pcm_cnt [NUM_PAIRS*PCMS_PER];
    logic [1:0]  trk_slot [NUM_PAIRS*PCMS_PER*SLOTS];
    logic [12:0] trk_total;

    logic [87:0]  record_q [$];
    t_call_result expected_q [$];
    int           errors;
    int           watchdog_cnt;
    int           in_gap;
    int           out_gap;
    logic [87:0]  last_rec;

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_call_result track_record(logic [87:0] rec);
        t_call_result res;
        logic [7:0]  typ, d1, d2, d3, o1, o2, o3, pcm, ts, code;
        logic [63:0] lo;
        logic [15:0] hi;
        logic [31:0] lab;
        logic [15:0] cic;
        logic [47:0] fwd, rev;
        int pair, pe, base, s;
        typ = rec[7:0];
        lo = rec[71:8];
        hi = rec[87:72];
        res = '0;
        res.total_act = trk_total;
        if (typ == TYPE_PACKED) begin
            lab = lo[31:0];
            cic = lo[47:32];
            d1 = {5'd0, lab[27:25]}; d2 = lab[24:17]; d3 = {5'd0, lab[16:14]};
            o1 = {5'd0, lab[13:11]}; o2 = lab[10:3]; o3 = {5'd0, lab[2:0]};
            pcm = {1'b0, cic[11:5]};
            ts = {3'd0, cic[4:0]};
            code = lo[55:48];
        end else if (typ == TYPE_BYTES) begin
            d3 = lo[7:0]; d2 = lo[15:8]; d1 = lo[23:16];
            o3 = lo[31:24]; o2 = lo[39:32]; o1 = lo[47:40];
            ts = lo[63:56]; pcm = hi[7:0]; code = hi[15:8];
        end else begin
            res.status = STS_IGNORED;
            return res;
        end
        fwd = {d1, d2, d3, o1, o2, o3};
        rev = {o1, o2, o3, d1, d2, d3};
        pair = -1;
        pe = -1;
        for (int i = 0; i < NUM_PAIRS && pair < 0; i++)
            if (trk_pair_vld[i] && (trk_key[i] == fwd || trk_key[i] == rev)) pair = i;
        for (int i = 0; i < NUM_PAIRS && pair < 0; i++)
            if (!trk_pair_vld[i]) begin
                pair = i;
                trk_pair_vld[i] = 1'b1;
                trk_key[i] = fwd;
                trk_pair_cnt[i] = '0;
            end
        res.status = STS_FULL;
        if (pair < 0) return res;
        res.pair_act = trk_pair_cnt[pair];
        base = pair * PCMS_PER;
        for (int i = 0; i < PCMS_PER && pe < 0; i++)
            if (trk_pcm_vld[base+i] && trk_pcm_id[base+i] == pcm) pe = base + i;
        for (int i = 0; i < PCMS_PER && pe < 0; i++)
            if (!trk_pcm_vld[base+i]) begin
                pe = base + i;
                trk_pcm_vld[pe] = 1'b1;
                trk_pcm_id[pe] = pcm;
                trk_pcm_cnt[pe] = '0;
                for (int k = 0; k < SLOTS; k++) trk_slot[pe*SLOTS+k] = ST_UNKNOWN;
            end
        if (pe < 0) return res;
        if (ts >= SLOTS) begin
            res.status = STS_RANGE;
            res.pcm_act = trk_pcm_cnt[pe];
            return res;
        end
        s = pe * SLOTS + ts;
        if (trk_slot[s] == ST_ACTIVE) begin
            if (code == CODE_REL) begin
                trk_slot[s] = ST_IDLE;
                if (trk_pcm_cnt[pe] != 0) trk_pcm_cnt[pe]--;
                if (trk_pair_cnt[pair] != 0) trk_pair_cnt[pair]--;
                if (trk_total != 0) trk_total--;
            end
        end else if (code == CODE_ANM) begin
            trk_slot[s] = ST_ACTIVE;
            trk_pcm_cnt[pe]++;
            trk_pair_cnt[pair]++;
            trk_total++;
        end else if (code == CODE_REL && trk_slot[s] == ST_UNKNOWN) begin
            trk_slot[s] = ST_IDLE;
        end
        res.status = STS_APPLIED;
        res.cstate = trk_slot[s];
        res.pcm_act = trk_pcm_cnt[pe];
        res.pair_act = trk_pair_cnt[pair];
        res.total_act = trk_total;
        return res;
    endfunction

    function automatic logic [87:0] packed_rec(logic [2:0] d1, logic [7:0] d2,
            logic [2:0] d3, logic [2:0] o1, logic [7:0] o2, logic [2:0] o3,
            logic [6:0] pcm, logic [4:0] ts, logic [7:0] code);
        logic [63:0] lo;
        lo = {$urandom(), $urandom()};
        lo[27:0] = {d1, d2, d3, o1, o2, o3};
        lo[31:28] = 4'($urandom_range(0, 15));
        lo[47:32] = {4'($urandom_range(0, 15)), pcm, ts};
        lo[55:48] = code;
        return {16'($urandom()), lo, TYPE_PACKED};
    endfunction

    function automatic logic [87:0] bytes_rec(logic [47:0] key, logic [7:0] pcm,
            logic [7:0] ts, logic [7:0] code);
        return {code, pcm, ts, 8'($urandom_range(0, 255)), key[23:0], key[47:24],
                TYPE_BYTES};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            in_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) expected_q.push_back(track_record(last_rec));
            if (in_gap > 0 || record_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (in_gap > 0) in_gap <= in_gap - 1;
            end else begin
                last_rec = record_q.pop_front();
                s_axis_tdata <= last_rec;
                s_axis_tvalid <= 1'b1;
                in_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_call_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", got, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.cstate != want.cstate)
                        report_mismatch("circuit_state", got.cstate, want.cstate);
                    if (got.pcm_act != want.pcm_act)
                        report_mismatch("pcm_active", got.pcm_act, want.pcm_act);
                    if (got.pair_act != want.pair_act)
                        report_mismatch("pair_active", got.pair_act, want.pair_act);
                    if (got.total_act != want.total_act)
                        report_mismatch("total_active", got.total_act, want.total_act);
                end
            end
            if (out_gap > 0) begin
                m_axis_tready <= 1'b0;
                out_gap <= out_gap - 1;
            end else begin
                m_axis_tready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            watchdog_cnt <= 0;
        else
            watchdog_cnt <= watchdog_cnt + 1;
        if (watchdog_cnt >= WATCHDOG) begin
            $display("signalling_circuit_call_tracker: mismatch");
            $finish;
        end
    end

    initial begin
        logic [47:0] keys [24];
        logic [7:0]  pcms [24][10];
        logic [47:0] k;
        logic [7:0]  code;
        int          r, p;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        trk_total = '0;
        for (int i = 0; i < NUM_PAIRS; i++) begin
            trk_key[i] = '0;
            trk_pair_vld[i] = 1'b0;
            trk_pair_cnt[i] = '0;
        end
        for (int i = 0; i < NUM_PAIRS*PCMS_PER; i++) begin
            trk_pcm_id[i] = '0;
            trk_pcm_vld[i] = 1'b0;
            trk_pcm_cnt[i] = '0;
        end
        for (int i = 0; i < NUM_PAIRS*PCMS_PER*SLOTS; i++) trk_slot[i] = ST_UNKNOWN;

        record_q.push_back({80'h0, 8'h00});
        record_q.push_back({{10{8'hff}}, 8'hff});
        record_q.push_back({80'h0, 8'h84});
        record_q.push_back(packed_rec(3'd0, 8'd0, 3'd0, 3'd0, 8'd0, 3'd0, 7'd0, 5'd0, CODE_ANM));
        record_q.push_back(packed_rec(3'd7, 8'hff, 3'd7, 3'd7, 8'hff, 3'd7, 7'h7f, 5'h1f,
                                      CODE_ANM));
        record_q.push_back(packed_rec(3'd7, 8'hff, 3'd7, 3'd7, 8'hff, 3'd7, 7'h7f, 5'h1f,
                                      CODE_ANM));
        record_q.push_back(packed_rec(3'd7, 8'hff, 3'd7, 3'd7, 8'hff, 3'd7, 7'h7f, 5'h1f,
                                      CODE_REL));
        record_q.push_back(packed_rec(3'd7, 8'hff, 3'd7, 3'd7, 8'hff, 3'd7, 7'h7f, 5'h1f,
                                      CODE_REL));
        record_q.push_back(packed_rec(3'd0, 8'd0, 3'd0, 3'd0, 8'd0, 3'd0, 7'd0, 5'd1, CODE_REL));
        record_q.push_back(packed_rec(3'd0, 8'd0, 3'd0, 3'd0, 8'd0, 3'd0, 7'd0, 5'd1, 8'h07));
        // reverse direction of an existing pair
        record_q.push_back(bytes_rec(48'h010203_040506, 8'h11, 8'd3, CODE_ANM));
        record_q.push_back(bytes_rec(48'h040506_010203, 8'h11, 8'd3, CODE_REL));
        record_q.push_back(bytes_rec(48'h040506_010203, 8'hff, 8'hff, CODE_ANM));
        record_q.push_back(bytes_rec(48'h040506_010203, 8'h11, 8'd32, CODE_ANM));
        // fill the PCM table of one pair, then overflow it
        for (int i = 0; i < 9; i++)
            record_q.push_back(bytes_rec(48'haabbcc_ddeeff, 8'(8'h20 + i), 8'd5, CODE_ANM));

        for (int i = 0; i < 24; i++) begin
            keys[i] = 48'({$urandom(), $urandom()});
            if (i < 12) keys[i] = {5'd0, keys[i][42:40], keys[i][39:32], 5'd0, keys[i][26:24],
                                   5'd0, keys[i][18:16], keys[i][15:8], 5'd0, keys[i][2:0]};
            for (int j = 0; j < 10; j++)
                pcms[i][j] = (i < 12) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255));
        end
        for (int n = 0; n < 1800; n++) begin
            r = $urandom_range(0, 99);
            p = (n < 900) ? $urandom_range(0, 13) : $urandom_range(0, 23);
            k = keys[p];
            if ($urandom_range(0, 1)) k = {k[23:0], k[47:24]};
            code = ($urandom_range(0, 9) < 4) ? CODE_ANM :
                   ($urandom_range(0, 5) < 4) ? CODE_REL : 8'($urandom_range(0, 255));
            if (r < 5) begin
                record_q.push_back(88'({$urandom(), $urandom(), $urandom()}));
            end else if (p < 12 && r < 55) begin
                record_q.push_back(packed_rec(k[42:40], k[39:32], k[26:24], k[18:16], k[15:8],
                                              k[2:0], pcms[p][$urandom_range(0, 9)][6:0],
                                              5'($urandom_range(0, 31)), code));
            end else begin
                record_q.push_back(bytes_rec(k, pcms[p][$urandom_range(0, 9)],
                                             ($urandom_range(0, 19) == 0) ?
                                             8'($urandom_range(32, 255)) :
                                             8'($urandom_range(0, 31)),
                                             code));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (record_q.size() == 0 && !s_axis_tvalid);
        wait (expected_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("signalling_circuit_call_tracker: match");
        else
            $display("signalling_circuit_call_tracker: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/scct_pkg.sv
sv/scct_ram.sv
sv/scct_ctrl.sv
sv/scct_dp.sv
sv/signalling_circuit_call_tracker.sv
tb/sv/tb_top.sv
